// ===== src/dirb_pkg.sv =====
// dirb_pkg: shared types and constants for the decay interval random bit core
// depends on nothing; used by every module under src
`timescale 1ns / 1ps

package dirb_pkg;

  // tick counter and time stamp width
  localparam int unsigned TIME_WIDTH = 32;
  localparam int unsigned THR_WIDTH  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_SLOTS  = 3;

  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(50);

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [THR_WIDTH-1:0]  thr_t;
  typedef logic [1:0]            slot_cnt_t;

  localparam slot_cnt_t SLOTS_FULL = slot_cnt_t'(NUM_SLOTS);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TUBE_ENABLE     = 8'd0,
    CFG_NOISE_THRESHOLD = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic tube_level;
    logic take_bit;
  } in_item_t;

  typedef struct packed {
    logic bit_valid;
    logic random_bit;
    logic bit_ready;
  } out_item_t;

  // input stage to engine transaction
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

// ===== src/decay_interval_random_bit_core.sv =====
// decay_interval_random_bit_core: top level of the tube interval random bit source
// depends on dirb_pkg, dirb_in_stage and dirb_engine
`timescale 1ns / 1ps
//
//  channel | direction | signals                               | payload
//  --------+-----------+---------------------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o               | in_item_i (in_item_t)
//  out     | output    | out_valid_o / out_ready_i             | out_item_o (out_item_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o             | cfg_index_i, cfg_data_i
//
//  one tick transaction per cycle unless the output stalls; an accepted transaction passes
//  the input register, then one compare and update pass into the result register
//  the tick counter advances once per transaction, not per clock
//  reset: enable 0, threshold 50, counter and slot count 0; no clearing pass
//  a stalled output holds the result; the input register still takes one more transaction
//  cfg writes are always ready and take effect on the next cycle

module decay_interval_random_bit_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  dirb_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output dirb_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dirb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dirb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  dirb_pkg::stage_t stage;
  logic             stage_ready;

  // input register
  dirb_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .stage_o       (stage),
    .stage_ready_i (stage_ready)
  );

  // capture logic and result register
  dirb_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

  // a served take empties the slots, so at most one remains afterwards
  a_served_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.bit_valid) |-> !out_item_o.bit_ready)
    else $error("bit served but slots still reported full");

  // a random bit only comes with a served take
  a_bit_needs_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.random_bit) |-> out_item_o.bit_valid)
    else $error("random bit set without a served take");

  // input back-pressure only from a stalled output
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output is free");

endmodule

// ===== src/dirb_in_stage.sv =====
// dirb_in_stage: input register holding one accepted tick transaction
// depends on dirb_pkg
`timescale 1ns / 1ps

module dirb_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dirb_pkg::in_item_t in_item_i,
  output dirb_pkg::stage_t  stage_o,
  input  logic              stage_ready_i
);

  logic              valid_q, valid_d;
  dirb_pkg::in_item_t item_q, item_d;

  // take a new transaction when empty or when the held one moves on
  assign in_ready_o = !valid_q || stage_ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d = in_item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== src/dirb_engine.sv =====
// dirb_engine: edge detection, pulse capture, interval compare and result register
// depends on dirb_pkg
`timescale 1ns / 1ps

module dirb_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dirb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dirb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  dirb_pkg::stage_t                    stage_i,
  output logic                                stage_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dirb_pkg::out_item_t                 out_item_o
);

  // configuration
  logic                 enable_q, enable_d;
  dirb_pkg::thr_t       thr_q, thr_d;
  logic                 cfg_clear;

  // tick state
  logic                 prev_level_q, prev_level_d;
  dirb_pkg::time_t      tick_q, tick_d;
  dirb_pkg::time_t      start_q, start_d;
  dirb_pkg::time_t      slot_q [dirb_pkg::NUM_SLOTS];
  dirb_pkg::slot_cnt_t  cnt_q, cnt_d, cnt_mid;

  // result register
  logic                 out_valid_q, out_valid_d;
  dirb_pkg::out_item_t  out_item_q, out_item_d;

  logic                 fire;
  logic                 serve;
  logic                 rise, fall;
  logic                 capture;
  dirb_pkg::time_t      width;
  dirb_pkg::time_t      d1, d2;
  logic                 bit_val;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    enable_d  = enable_q;
    thr_d     = thr_q;
    cfg_clear = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dirb_pkg::CFG_TUBE_ENABLE: begin
          enable_d  = cfg_data_i[0];
          cfg_clear = cfg_data_i[0];
        end
        dirb_pkg::CFG_NOISE_THRESHOLD: begin
          thr_d = cfg_data_i[dirb_pkg::THR_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // a held transaction moves into the result register when it is free
  assign fire          = stage_i.valid && (!out_valid_q || out_ready_i);
  assign stage_ready_o = !out_valid_q || out_ready_i;

  // take request on the state before this tick
  assign serve   = stage_i.item.take_bit && (cnt_q == dirb_pkg::SLOTS_FULL);
  assign d1      = slot_q[1] - slot_q[0];
  assign d2      = slot_q[2] - slot_q[1];
  assign bit_val = serve && !(d1 < d2);
  assign cnt_mid = serve ? '0 : cnt_q;

  // edge handling and capture qualification
  assign rise    = stage_i.item.tube_level && !prev_level_q;
  assign fall    = !stage_i.item.tube_level && prev_level_q;
  assign width   = tick_q - start_q;
  assign capture = fall && enable_q && (cnt_mid != dirb_pkg::SLOTS_FULL)
                   && (width > dirb_pkg::time_t'(thr_q));

  always_comb begin
    prev_level_d = prev_level_q;
    tick_d       = tick_q;
    start_d      = start_q;
    cnt_d        = cnt_q;
    if (fire) begin
      prev_level_d = stage_i.item.tube_level;
      tick_d       = tick_q + dirb_pkg::time_t'(1);
      cnt_d        = capture ? cnt_mid + 2'd1 : cnt_mid;
      if (rise) begin
        start_d = tick_q;
      end
    end
    if (cfg_clear) begin
      cnt_d = '0;
    end
  end

  // result register next value
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d           = 1'b1;
      out_item_d.bit_valid  = serve;
      out_item_d.random_bit = bit_val;
      out_item_d.bit_ready  = (cnt_d == dirb_pkg::SLOTS_FULL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      thr_q        <= dirb_pkg::THR_RESET;
      prev_level_q <= 1'b0;
      tick_q       <= '0;
      start_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      enable_q     <= enable_d;
      thr_q        <= thr_d;
      prev_level_q <= prev_level_d;
      tick_q       <= tick_d;
      start_q      <= start_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // capture slots and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (fire && capture) begin
      slot_q[cnt_mid] <= start_q;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== verif/decay_interval_random_bit_core_tb.sv =====
// decay_interval_random_bit_core_tb: self-checking bench for the tube interval random bit core
// depends on dirb_pkg and decay_interval_random_bit_core; a scoreboard class predicts every tick
`timescale 1ns / 1ps

module decay_interval_random_bit_core_tb;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // no register lives at this index, so writes to it must be dropped
  localparam logic [dirb_pkg::CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = '1;

  // predicts one result per tick transaction and checks results in order
  class rand_bit_scoreboard;
    logic                 tube_on;
    dirb_pkg::thr_t       noise_thr;
    logic                 last_level;
    dirb_pkg::time_t      tick_count;
    dirb_pkg::time_t      pulse_start;
    dirb_pkg::time_t      stamps [dirb_pkg::NUM_SLOTS];
    dirb_pkg::slot_cnt_t  n_captured;
    dirb_pkg::out_item_t  expected_results [$];
    int unsigned          n_errors;
    int unsigned          n_checked;
    int unsigned          n_bits;
    int unsigned          n_ones;
    int unsigned          n_captures;

    function new();
      tube_on     = 1'b0;
      noise_thr   = dirb_pkg::THR_RESET;
      last_level  = 1'b0;
      tick_count  = '0;
      pulse_start = '0;
      n_captured  = '0;
      n_errors    = 0;
      n_checked   = 0;
      n_bits      = 0;
      n_ones      = 0;
      n_captures  = 0;
    endfunction

    function void write_reg(logic [dirb_pkg::CFG_IDX_W-1:0]  idx,
                            logic [dirb_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dirb_pkg::CFG_TUBE_ENABLE: begin
          tube_on = data[0];
          if (tube_on) n_captured = '0;
        end
        dirb_pkg::CFG_NOISE_THRESHOLD: noise_thr = dirb_pkg::thr_t'(data);
        default: ;
      endcase
    endfunction

    // take is served from the old slots, then the edge, then the counter moves
    function void note_tick(dirb_pkg::in_item_t it);
      dirb_pkg::out_item_t want;
      dirb_pkg::time_t     d1;
      dirb_pkg::time_t     d2;
      dirb_pkg::time_t     width;
      want = '0;
      if (it.take_bit && n_captured == dirb_pkg::SLOTS_FULL) begin
        d1 = stamps[1] - stamps[0];
        d2 = stamps[2] - stamps[1];
        want.bit_valid  = 1'b1;
        want.random_bit = (d1 < d2) ? 1'b0 : 1'b1;
        n_captured = '0;
      end
      if (it.tube_level && !last_level) begin
        pulse_start = tick_count;
      end else if (!it.tube_level && last_level) begin
        width = tick_count - pulse_start;
        if (width > dirb_pkg::time_t'(noise_thr) && tube_on
            && n_captured < dirb_pkg::SLOTS_FULL) begin
          stamps[n_captured] = pulse_start;
          n_captured = n_captured + 1'b1;
          n_captures++;
        end
      end
      last_level = it.tube_level;
      tick_count = tick_count + 1'b1;
      want.bit_ready = (n_captured == dirb_pkg::SLOTS_FULL);
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(dirb_pkg::out_item_t got);
      dirb_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with no tick pending: %b", got);
        n_errors++;
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      if (want.bit_valid) begin
        n_bits++;
        if (want.random_bit) n_ones++;
      end
      compare_field("bit_valid", want.bit_valid, got.bit_valid);
      compare_field("random_bit", want.random_bit, got.random_bit);
      compare_field("bit_ready", want.bit_ready, got.bit_ready);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  dirb_pkg::in_item_t              in_item_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  dirb_pkg::out_item_t             out_item_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [dirb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [dirb_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  rand_bit_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_sent        = 0;
  int unsigned n_cycles      = 0;

  decay_interval_random_bit_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // result side: random back-pressure and in-order checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one tick transaction, with random idle cycles ahead of it
  task automatic send_tick(logic level, logic take);
    dirb_pkg::in_item_t it;
    it.tube_level = level;
    it.take_bit   = take;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(it);
    n_sent++;
  endtask

  // hi ticks high, lo ticks low, optional take on the falling edge tick
  task automatic send_pulse(int unsigned hi, int unsigned lo, logic take_on_fall);
    for (int unsigned i = 0; i < hi; i++) send_tick(1'b1, 1'b0);
    for (int unsigned i = 0; i < lo; i++) send_tick(1'b0, take_on_fall && i == 0);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [dirb_pkg::CFG_IDX_W-1:0]  idx,
                           logic [dirb_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // takes are frequent once three pulses are held, rare otherwise
  function automatic logic pick_take();
    if (sb.n_captured == dirb_pkg::SLOTS_FULL) return 1'($urandom_range(0, 1));
    return ($urandom_range(0, 24) == 0);
  endfunction

  task automatic run_directed();
    // disabled: pulse stamped but not captured, take refused
    cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, 16'd1);
    send_pulse(3, 1, 1'b1);
    // enable with stray upper data bits
    wait_drained();
    cfg_write(dirb_pkg::CFG_TUBE_ENABLE, 16'hFFFF);
    // width equal to the threshold is rejected
    send_pulse(1, 1, 1'b0);
    // take on empty slots in the same tick as a capture
    send_pulse(2, 1, 1'b1);
    send_pulse(3, 1, 1'b0);
    // writing enable again drops the two held pulses
    wait_drained();
    cfg_write(dirb_pkg::CFG_TUBE_ENABLE, 16'h0001);
    // intervals 3 then 5, then a fourth pulse while full is dropped
    send_pulse(2, 1, 1'b0);
    send_pulse(4, 1, 1'b0);
    send_pulse(2, 1, 1'b0);
    send_pulse(2, 1, 1'b0);
    send_tick(1'b0, 1'b1);
    // equal intervals give a one
    send_pulse(2, 1, 1'b0);
    send_pulse(2, 1, 1'b0);
    send_pulse(2, 1, 1'b0);
    // take while full lands on a qualifying falling edge
    send_pulse(3, 1, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  // mostly well-formed pulses around the threshold, some raw noise
  task automatic run_random(int unsigned budget);
    int unsigned stop_at;
    int unsigned thr;
    int unsigned hi;
    int unsigned lo;
    stop_at = n_sent + budget;
    while (n_sent < stop_at) begin
      thr = int'(sb.noise_thr);
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 3))
          0: hi = (thr == 0) ? 1 : thr;
          1: hi = $urandom_range(1, (thr < 2) ? 1 : thr);
          default: hi = thr + 1 + $urandom_range(0, 5);
        endcase
        lo = $urandom_range(1, 10);
        repeat (hi) send_tick(1'b1, pick_take());
        repeat (lo) send_tick(1'b0, pick_take());
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    send_pct = '{9, 62, 0};
    recv_pct = '{62, 9, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    run_directed();

    // three idle profiles, each over several register settings
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      for (int seg = 0; seg < 4; seg++) begin
        wait_drained();
        case (seg)
          0: begin
            cfg_write(dirb_pkg::CFG_TUBE_ENABLE, {15'($urandom), 1'b1});
            cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, '0);
            run_random(130);
          end
          1: begin
            cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, 16'($urandom_range(1, 6)));
            run_random(170);
          end
          2: begin
            cfg_write(dirb_pkg::CFG_TUBE_ENABLE, {15'($urandom), 1'b0});
            cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, 16'($urandom_range(2, 8)));
            run_random(50);
          end
          default: begin
            cfg_write(CFG_IDX_UNMAPPED, 16'($urandom));
            cfg_write(dirb_pkg::CFG_TUBE_ENABLE, 16'h0001);
            cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, 16'($urandom_range(8, 16)));
            run_random(170);
          end
        endcase
      end
    end

    // largest threshold: no pulse of this run can qualify
    wait_drained();
    cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, 16'hFFFF);
    cfg_write(dirb_pkg::CFG_TUBE_ENABLE, 16'h0001);
    send_pulse(40, 2, 1'b0);
    // wide threshold: one pulse just at it, one just over
    wait_drained();
    cfg_write(dirb_pkg::CFG_NOISE_THRESHOLD, 16'd100);
    send_pulse(100, 2, 1'b0);
    send_pulse(101, 2, 1'b1);
    wait_drained();

    $display("covered %0d tick transactions, thresholds 0 to 65535, tube enabled and disabled",
             n_sent);
    $display("%0d results checked, %0d bits delivered (%0d ones), %0d pulses captured",
             sb.n_checked, sb.n_bits, sb.n_ones, sb.n_captures);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
